@@ design/ihrf_pkg.sv @@
// ----------------------------------------------------------------------------
// ihrf_pkg
// Shared types and constants of the IPv4 header rule filter.
// ----------------------------------------------------------------------------
package ihrf_pkg;

  localparam int RULE_ENTRIES = 64;

  localparam logic [1:0] CMD_BYTE = 2'd0;
  localparam logic [1:0] CMD_RULE = 2'd1;
  localparam logic [1:0] CMD_STAT = 2'd2;

  localparam logic [2:0] CLS_MALFORMED = 3'd0;
  localparam logic [2:0] CLS_OTHER     = 3'd1;
  localparam logic [2:0] CLS_NO_RULE   = 3'd2;
  localparam logic [2:0] CLS_DROP      = 3'd3;
  localparam logic [2:0] CLS_PASS      = 3'd4;
  localparam logic [2:0] CLS_REDIRECT  = 3'd5;

  localparam logic [1:0] ACT_DROP     = 2'd0;
  localparam logic [1:0] ACT_REDIRECT = 2'd2;

  localparam logic [2:0] ST_TOTAL      = 3'd0;
  localparam logic [2:0] ST_PASSED     = 3'd1;
  localparam logic [2:0] ST_DROPPED    = 3'd2;
  localparam logic [2:0] ST_REDIRECTED = 3'd3;
  localparam logic [2:0] ST_TCP        = 3'd4;
  localparam logic [2:0] ST_UDP        = 3'd5;
  localparam logic [2:0] ST_OTHER      = 3'd6;
  localparam logic [2:0] ST_MALFORMED  = 3'd7;

  localparam logic [31:0] SUBNET_MASK    = 32'hFFFF_FF00;
  localparam logic [3:0]  MIN_IHL        = 4'd5;
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;

  // job from front part to back part
  typedef struct packed {
    logic        is_stat;   // 1 counter read
    logic        is_rule;   // 1 rule table write
    logic [2:0]  stat_sel;
    logic [2:0]  pre_class; // class if no lookup
    logic        lookup;    // rule lookup decides
    logic        is_tcp;
    logic        is_udp;
    logic [5:0]  rule_slot;
    logic [1:0]  rule_act;
    logic        rule_en;
    logic [31:0] key;       // lookup key or rule key
  } job_t;

endpackage

@@ design/ihrf_front.sv @@
// ----------------------------------------------------------------------------
// ihrf_front
// Parse packet bytes and classify; emit verdict, rule-write or counter-read
// jobs in arrival order.
// ----------------------------------------------------------------------------
module ihrf_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_fire,
  input  logic [1:0]         cmd,
  input  logic [7:0]         byte_value,
  input  logic               last_byte,
  input  logic [5:0]         rule_slot,
  input  logic [31:0]        rule_match_key,
  input  logic [1:0]         rule_verdict_code,
  input  logic               rule_enable,
  input  logic [2:0]         stat_select,
  output logic               job_valid,
  output ihrf_pkg::job_t     job
);
  import ihrf_pkg::*;

  logic [15:0] byte_position;
  logic [15:0] saved_ethertype;
  logic [3:0]  header_words;
  logic [7:0]  saved_protocol;
  logic [31:0] saved_destination;

  logic [15:0] len;
  logic [15:0] eth_next;
  logic [3:0]  ihl_next;
  logic [7:0]  proto_next;
  logic [31:0] dest_next;
  logic [16:0] need;
  job_t        verdict;
  job_t        rule_job;
  job_t        stat_job;

  always_comb begin
    eth_next   = saved_ethertype;
    ihl_next   = header_words;
    proto_next = saved_protocol;
    dest_next  = saved_destination;
    if (byte_position == 16'd12) eth_next = {byte_value, saved_ethertype[7:0]};
    else if (byte_position == 16'd13) eth_next = {saved_ethertype[15:8], byte_value};
    else if (byte_position == 16'd14) ihl_next = byte_value[3:0];
    else if (byte_position == 16'd23) proto_next = byte_value;
    else if (byte_position >= 16'd30 && byte_position <= 16'd33)
      dest_next = {saved_destination[23:0], byte_value};
    len  = (byte_position == 16'hFFFF) ? 16'hFFFF : byte_position + 16'd1;
    need = 17'd14 + {11'd0, ihl_next, 2'b00};

    verdict           = '0;
    verdict.key       = (dest_next & SUBNET_MASK) | {24'd0, proto_next};
    verdict.pre_class = CLS_MALFORMED;
    if (len < 16'd14) begin
      verdict.pre_class = CLS_MALFORMED;
    end else if (eth_next != ETHERTYPE_IPV4) begin
      verdict.pre_class = CLS_OTHER;
    end else if (len < 16'd34 || ihl_next < MIN_IHL) begin
      verdict.pre_class = CLS_MALFORMED;
    end else if (proto_next == PROTO_TCP) begin
      if ({1'b0, len} >= need + 17'd20) begin
        verdict.lookup = 1'b1;
        verdict.is_tcp = 1'b1;
      end
    end else if (proto_next == PROTO_UDP) begin
      if ({1'b0, len} >= need + 17'd8) begin
        verdict.lookup = 1'b1;
        verdict.is_udp = 1'b1;
      end
    end else begin
      verdict.pre_class = CLS_OTHER;
    end

    rule_job           = '0;
    rule_job.is_rule   = 1'b1;
    rule_job.rule_slot = rule_slot;
    rule_job.rule_act  = rule_verdict_code;
    rule_job.rule_en   = rule_enable;
    rule_job.key       = rule_match_key;

    stat_job          = '0;
    stat_job.is_stat  = 1'b1;
    stat_job.stat_sel = stat_select;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      saved_ethertype   <= '0;
      header_words      <= '0;
      saved_protocol    <= '0;
      saved_destination <= '0;
      job_valid         <= 1'b0;
    end else begin
      job_valid <= 1'b0;
      if (in_fire && cmd == CMD_BYTE) begin
        if (last_byte) begin
          byte_position     <= '0;
          saved_ethertype   <= '0;
          header_words      <= '0;
          saved_protocol    <= '0;
          saved_destination <= '0;
          job_valid         <= 1'b1;
          job               <= verdict;
        end else begin
          byte_position     <= len;
          saved_ethertype   <= eth_next;
          header_words      <= ihl_next;
          saved_protocol    <= proto_next;
          saved_destination <= dest_next;
        end
      end else if (in_fire && cmd == CMD_RULE) begin
        job_valid <= 1'b1;
        job       <= rule_job;
      end else if (in_fire && cmd == CMD_STAT) begin
        job_valid <= 1'b1;
        job       <= stat_job;
      end
    end
  end
endmodule

@@ design/ihrf_queue.sv @@
// ----------------------------------------------------------------------------
// ihrf_queue
// Short job queue between front and back parts.
// ----------------------------------------------------------------------------
module ihrf_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  ihrf_pkg::job_t wr_job,
  output logic [2:0]     used,
  output logic           rd_valid,
  input  logic           rd_en,
  output ihrf_pkg::job_t rd_job
);
  import ihrf_pkg::*;

  job_t       mem [4];
  logic [1:0] wp;
  logic [1:0] rp;

  assign rd_valid = used != 3'd0;
  assign rd_job   = mem[rp];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wp] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      rp   <= '0;
      used <= '0;
    end else begin
      if (wr_en) wp <= wp + 2'd1;
      if (rd_en) rp <= rp + 2'd1;
      used <= used + {2'd0, wr_en} - {2'd0, rd_en};
    end
  end
endmodule

@@ design/ihrf_back.sv @@
// ----------------------------------------------------------------------------
// ihrf_back
// Rule table writes and lookup, statistics counters and output register.
// ----------------------------------------------------------------------------
module ihrf_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_valid,
  input  ihrf_pkg::job_t job,
  output logic           job_take,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           out_kind,
  output logic [71:0]    out_data
);
  import ihrf_pkg::*;

  logic [31:0] table_keys    [RULE_ENTRIES];
  logic [1:0]  table_actions [RULE_ENTRIES];
  logic [RULE_ENTRIES-1:0] table_valid;
  logic [63:0] stat_counters [8];

  logic [RULE_ENTRIES-1:0] hit;
  logic        any_hit;
  logic [1:0]  act;
  logic [2:0]  cls;
  logic        pass;
  logic [7:0]  inc;
  logic        emit;

  assign job_take = job_valid && (job.is_rule || !out_valid || out_ready);
  assign emit     = job_take && !job.is_rule;

  always_comb begin
    for (int i = 0; i < RULE_ENTRIES; i++)
      hit[i] = table_valid[i] && table_keys[i] == job.key;
    any_hit = 1'b0;
    act     = '0;
    for (int i = RULE_ENTRIES - 1; i >= 0; i--) begin
      if (hit[i]) begin
        any_hit = 1'b1;
        act     = table_actions[i];
      end
    end
    inc = '0;
    cls = job.pre_class;
    pass = 1'b0;
    if (!job.is_stat && !job.is_rule) begin
      inc[ST_TOTAL] = 1'b1;
      if (job.lookup) begin
        inc[ST_TCP] = job.is_tcp;
        inc[ST_UDP] = job.is_udp;
        pass = 1'b1;
        if (!any_hit) begin
          cls = CLS_NO_RULE;
          inc[ST_PASSED] = 1'b1;
        end else if (act == ACT_DROP) begin
          cls  = CLS_DROP;
          pass = 1'b0;
          inc[ST_DROPPED] = 1'b1;
        end else if (act == ACT_REDIRECT) begin
          cls = CLS_REDIRECT;
          inc[ST_REDIRECTED] = 1'b1;
        end else begin
          cls = CLS_PASS;
          inc[ST_PASSED] = 1'b1;
        end
      end else if (cls == CLS_OTHER) begin
        pass = 1'b1;
        inc[ST_OTHER] = 1'b1;
      end else begin
        inc[ST_MALFORMED] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_take && job.is_rule) begin
      table_keys[job.rule_slot]    <= job.key;
      table_actions[job.rule_slot] <= job.rule_act;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      table_valid <= '0;
      out_valid   <= 1'b0;
      for (int i = 0; i < 8; i++) stat_counters[i] <= '0;
    end else begin
      if (job_take && job.is_rule) table_valid[job.rule_slot] <= job.rule_en;
      out_valid <= emit || (out_valid && !out_ready);
      if (emit) begin
        out_kind <= job.is_stat;
        if (job.is_stat)
          out_data <= {4'd0, stat_counters[job.stat_sel], 3'd0, 1'b0};
        else
          out_data <= {4'd0, 64'd0, cls, pass};
      end
      if (job_take) begin
        for (int i = 0; i < 8; i++)
          if (inc[i]) stat_counters[i] <= stat_counters[i] + 64'd1;
      end
    end
  end
endmodule

@@ design/ipv4_header_rule_filter.sv @@
// ----------------------------------------------------------------------------
// ipv4_header_rule_filter
// Ethernet/IPv4/TCP/UDP header filter with rule table and counters.
// ----------------------------------------------------------------------------
// Input stream s_axis: one transfer per command. tuser holds cmd; packet
// bytes (cmd 0) carry tlast on the final byte. Rule writes (cmd 1) give no
// result; counter reads (cmd 2) and final packet bytes each give one result
// transfer on m_axis, with m_axis_tuser set for counter read data.
// Throughput: one input transfer per cycle while s_axis_tready is high. A
// verdict or counter read reaches m_axis through the front register, the
// job queue, then the output register after table compare. Rule writes travel
// through the same queue, so every command takes effect in arrival order.
// A four-entry job queue sits between parser and table; s_axis_tready drops
// when it may fill, so a stalled m_axis holds results without loss.
// Reset clears the parser, rule valid bits, counters and queue.
// ----------------------------------------------------------------------------
module ipv4_header_rule_filter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // byte_value[7:0], rule_slot[13:8], rule_match_key[45:14],
  // rule_verdict_code[47:46], rule_enable[48], stat_select[51:49]
  input  logic [55:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic [1:0]  s_axis_tuser,   // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pass_flag[0], packet_class[3:1], counter_value[67:4]
  output logic [71:0] m_axis_tdata,
  output logic        m_axis_tuser    // result_kind
);
  import ihrf_pkg::*;

  logic       in_fire;
  logic       f_valid;
  job_t       f_job;
  logic [2:0] used;
  logic       q_valid;
  logic       q_take;
  job_t       q_job;

  // room for queued jobs plus the one in the front register
  assign s_axis_tready = (used + {2'd0, f_valid}) < 3'd3;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  ihrf_front u_front (
    .clk, .rst, .in_fire,
    .cmd               (s_axis_tuser),
    .byte_value        (s_axis_tdata[7:0]),
    .last_byte         (s_axis_tlast),
    .rule_slot         (s_axis_tdata[13:8]),
    .rule_match_key    (s_axis_tdata[45:14]),
    .rule_verdict_code (s_axis_tdata[47:46]),
    .rule_enable       (s_axis_tdata[48]),
    .stat_select       (s_axis_tdata[51:49]),
    .job_valid         (f_valid),
    .job               (f_job)
  );

  ihrf_queue u_queue (
    .clk, .rst,
    .wr_en    (f_valid),
    .wr_job   (f_job),
    .used     (used),
    .rd_valid (q_valid),
    .rd_en    (q_take),
    .rd_job   (q_job)
  );

  ihrf_back u_back (
    .clk, .rst,
    .job_valid (q_valid),
    .job       (q_job),
    .job_take  (q_take),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_kind  (m_axis_tuser),
    .out_data  (m_axis_tdata)
  );
endmodule

@@ tb/sv/tb_ipv4_header_rule_filter.sv @@
// ----------------------------------------------------------------------------
// tb_ipv4_header_rule_filter
// Self-checking bench for the IPv4 header rule filter: rule table writes,
// counter reads and packet byte streams go in over s_axis, each verdict and
// counter value on m_axis is compared against a local predictor.
// ----------------------------------------------------------------------------
module tb_ipv4_header_rule_filter;
  import ihrf_pkg::*;

  localparam int  LIMIT_CYCLES = 1500000;
  localparam int  DRAIN_CYCLES = 20;

  typedef struct {
    logic        kind;
    logic        pass;
    logic [2:0]  cls;
    logic [63:0] value;
  } verdict_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tuser;

  ipv4_header_rule_filter u_dut (.*);

  // predictor state
  logic [15:0] pkt_pos;
  logic [15:0] pkt_ethertype;
  logic [3:0]  pkt_ihl;
  logic [7:0]  pkt_proto;
  logic [31:0] pkt_dest;
  logic [31:0] rule_key [64];
  logic [1:0]  rule_act [64];
  logic        rule_on  [64];
  logic [63:0] stats    [8];

  verdict_t    expected_q[$];
  int          fails = 0;
  int          cycles = 0;
  int          verdicts_seen = 0;
  int          reads_seen = 0;
  int          burst_left = 0;
  bit          stall_mode = 0;

  // keys of enabled rule writes, so random packets hit rules
  logic [31:0] key_pool[$];

  initial forever #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if (rst) m_axis_tready <= 0;
    else if (stall_mode) m_axis_tready <= ($urandom_range(0, 3) == 0);
    else m_axis_tready <= ($urandom_range(0, 15) != 0);
  end

  always @(posedge clk) begin
    verdict_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result transfer %h %h", m_axis_tuser, m_axis_tdata);
        fails++;
      end else begin
        e = expected_q.pop_front();
        if (m_axis_tuser !== e.kind) begin
          $error("result_kind exp %0d got %0d", e.kind, m_axis_tuser); fails++;
        end
        if (m_axis_tdata[0] !== e.pass) begin
          $error("pass_flag exp %0d got %0d", e.pass, m_axis_tdata[0]); fails++;
        end
        if (m_axis_tdata[3:1] !== e.cls) begin
          $error("packet_class exp %0d got %0d", e.cls, m_axis_tdata[3:1]); fails++;
        end
        if (m_axis_tdata[67:4] !== e.value) begin
          $error("counter_value exp %0h got %0h", e.value, m_axis_tdata[67:4]); fails++;
        end
        if (e.kind) reads_seen++; else verdicts_seen++;
      end
    end
  end

  function automatic void bump(logic [2:0] which);
    stats[which] = stats[which] + 64'd1;
  endfunction

  function automatic logic [2:0] judge_packet(logic [15:0] len, output logic pass);
    logic [31:0] need;
    logic [31:0] key;
    pass = 0;
    bump(ST_TOTAL);
    if (len < 14) begin bump(ST_MALFORMED); return CLS_MALFORMED; end
    if (pkt_ethertype != ETHERTYPE_IPV4) begin
      bump(ST_OTHER); pass = 1; return CLS_OTHER;
    end
    if (len < 34 || pkt_ihl < MIN_IHL) begin bump(ST_MALFORMED); return CLS_MALFORMED; end
    need = 14 + pkt_ihl * 4;
    if (pkt_proto == PROTO_TCP) begin
      if (len < need + 20) begin bump(ST_MALFORMED); return CLS_MALFORMED; end
      bump(ST_TCP);
    end else if (pkt_proto == PROTO_UDP) begin
      if (len < need + 8) begin bump(ST_MALFORMED); return CLS_MALFORMED; end
      bump(ST_UDP);
    end else begin
      bump(ST_OTHER); pass = 1; return CLS_OTHER;
    end
    key = (pkt_dest & SUBNET_MASK) | {24'd0, pkt_proto};
    for (int i = 0; i < 64; i++) begin
      if (rule_on[i] && rule_key[i] == key) begin
        if (rule_act[i] == ACT_DROP) begin bump(ST_DROPPED); return CLS_DROP; end
        pass = 1;
        if (rule_act[i] == ACT_REDIRECT) begin bump(ST_REDIRECTED); return CLS_REDIRECT; end
        bump(ST_PASSED); return CLS_PASS;
      end
    end
    bump(ST_PASSED);
    pass = 1;
    return CLS_NO_RULE;
  endfunction

  function automatic void predict(logic [1:0] cmd, logic [55:0] d, logic last);
    verdict_t e;
    logic     p;
    if (cmd == CMD_BYTE) begin
      case (pkt_pos)
        12: pkt_ethertype[15:8] = d[7:0];
        13: pkt_ethertype[7:0] = d[7:0];
        14: pkt_ihl = d[3:0];
        23: pkt_proto = d[7:0];
        default: if (pkt_pos >= 30 && pkt_pos <= 33) pkt_dest = {pkt_dest[23:0], d[7:0]};
      endcase
      if (pkt_pos != 16'hFFFF) pkt_pos = pkt_pos + 16'd1;
      if (last) begin
        e.kind = 0;
        e.value = '0;
        e.cls = judge_packet(pkt_pos, p);
        e.pass = p;
        expected_q.push_back(e);
        pkt_pos = 0; pkt_ethertype = 0; pkt_ihl = 0; pkt_proto = 0; pkt_dest = 0;
      end
    end else if (cmd == CMD_RULE) begin
      rule_key[d[13:8]] = d[45:14];
      rule_act[d[13:8]] = d[47:46];
      rule_on[d[13:8]] = d[48];
    end else if (cmd == CMD_STAT) begin
      e.kind = 1; e.pass = 0; e.cls = CLS_MALFORMED;
      e.value = stats[d[51:49]];
      expected_q.push_back(e);
    end
  endfunction

  // send one transfer; sender idles in bursts
  task automatic send_item(logic [1:0] cmd, logic [55:0] d, logic last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
        s_axis_tvalid <= 0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid <= 1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= d;
    s_axis_tlast <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict(cmd, d, last);
    @(negedge clk);
  endtask

  task automatic write_rule(logic [5:0] slot, logic [31:0] key, logic [1:0] act, logic en);
    send_item(CMD_RULE, {4'd0, 3'($urandom), en, act, key, slot, 8'($urandom)},
              1'($urandom));
    if (en) key_pool.push_back(key);
  endtask

  task automatic read_stat(logic [2:0] sel);
    send_item(CMD_STAT, {4'd0, sel, 49'({$urandom, $urandom})}, 1'($urandom));
  endtask

  task automatic send_byte(logic [7:0] b, logic last);
    send_item(CMD_BYTE, {48'({$urandom, $urandom}), b}, last);
  endtask

  // header bytes for a packet; len may be shorter than the header
  task automatic send_packet(int len, logic [15:0] etype, logic [7:0] vihl,
                             logic [7:0] proto, logic [31:0] dest, bit mid_cmds);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      if (i == 12) b = etype[15:8];
      else if (i == 13) b = etype[7:0];
      else if (i == 14) b = vihl;
      else if (i == 23) b = proto;
      else if (i >= 30 && i <= 33) b = dest[8 * (33 - i) +: 8];
      if (mid_cmds && $urandom_range(0, 15) == 0) begin
        if ($urandom_range(0, 1)) read_stat(3'($urandom));
        else write_rule(6'($urandom), $urandom, 2'($urandom), 1'($urandom));
      end
      send_byte(b, i == len - 1);
    end
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_directed();
    write_rule(6'd0, {24'hC0A801, PROTO_TCP}, ACT_DROP, 1'b1);
    write_rule(6'd1, {24'hC0A801, PROTO_UDP}, ACT_REDIRECT, 1'b1);
    write_rule(6'd2, {24'h0A0000, PROTO_TCP}, 2'd3, 1'b1);
    write_rule(6'd3, {24'h0A0000, PROTO_TCP}, ACT_DROP, 1'b1);
    write_rule(6'd63, 32'hFFFFFFFF, 2'd1, 1'b1);
    write_rule(6'd63, 32'hFFFFFFFF, 2'd1, 1'b0);
    send_packet(1, 16'h0800, 8'h45, PROTO_TCP, 32'h0, 1'b0);
    send_packet(13, 16'h0800, 8'h45, PROTO_TCP, 32'h0, 1'b0);
    send_packet(14, 16'h86DD, 8'h45, PROTO_TCP, 32'h0, 1'b0);
    send_packet(33, 16'h0800, 8'h45, PROTO_TCP, 32'hC0A80101, 1'b0);
    send_packet(54, 16'h0800, 8'h44, PROTO_TCP, 32'hC0A80101, 1'b0);
    send_packet(54, 16'h0800, 8'h45, PROTO_TCP, 32'hC0A80155, 1'b0);
    send_packet(42, 16'h0800, 8'hF5, PROTO_UDP, 32'hC0A801FF, 1'b0);
    send_packet(53, 16'h0800, 8'h45, PROTO_TCP, 32'hC0A80101, 1'b0);
    send_packet(41, 16'h0800, 8'h45, PROTO_UDP, 32'hC0A80101, 1'b0);
    send_packet(60, 16'h0800, 8'h46, PROTO_TCP, 32'h0A000001, 1'b0);
    send_packet(40, 16'h0800, 8'h45, 8'd1, 32'h0A000001, 1'b0);
    send_packet(54, 16'h0800, 8'h45, PROTO_TCP, 32'h01020304, 1'b0);
    send_packet(64, 16'h0800, 8'h4F, PROTO_UDP, 32'hFFFFFFFF, 1'b1);
    send_item(2'd3, 56'hFFFFFFFFFFFFFF, 1'b1);
    for (int s = 0; s < 8; s++) read_stat(3'(s));
    wait_drain();
  endtask

  task automatic test_long_packet();
    stall_mode = 0;
    send_packet(400, 16'h0800, 8'h45, PROTO_UDP, 32'hC0A80101, 1'b0);
    wait_drain();
  endtask

  task automatic test_random();
    int items = 0;
    int len, pick;
    logic [31:0] dest;
    logic [7:0]  proto;
    while (items < 1100) begin
      if (($urandom_range(0, 199)) == 0) stall_mode = ~stall_mode;
      pick = $urandom_range(0, 19);
      if (pick < 2) begin
        write_rule(6'($urandom_range(0, 63)),
                   ($urandom & SUBNET_MASK) | ($urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP),
                   2'($urandom), $urandom_range(0, 3) != 0);
        items++;
      end else if (pick < 4) begin
        read_stat(3'($urandom));
        items++;
      end else if (pick < 5) begin
        send_item(2'd3, 56'({$urandom, $urandom}), 1'($urandom));
      end else begin
        proto = ($urandom_range(0, 9) == 0) ? 8'($urandom) :
                ($urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP);
        dest = {$urandom};
        if (key_pool.size() != 0 && $urandom_range(0, 1))
          dest = (key_pool[$urandom_range(0, key_pool.size() - 1)] & SUBNET_MASK) |
                 32'($urandom_range(0, 255));
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 70) : $urandom_range(42, 80);
        send_packet(len, ($urandom_range(0, 9) == 0) ? 16'($urandom) : ETHERTYPE_IPV4,
                    {4'($urandom), ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'd5},
                    proto, dest, 1);
        items += len;
      end
    end
    for (int s = 0; s < 8; s++) read_stat(3'(s));
    wait_drain();
  endtask

  initial begin
    pkt_pos = 0; pkt_ethertype = 0; pkt_ihl = 0; pkt_proto = 0; pkt_dest = 0;
    for (int i = 0; i < 64; i++) begin rule_on[i] = 0; rule_key[i] = 0; rule_act[i] = 0; end
    for (int i = 0; i < 8; i++) stats[i] = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    test_directed();
    test_random();
    test_long_packet();
    $display("Covered %0d verdicts and %0d counter reads, with rule writes,",
             verdicts_seen, reads_seen);
    $display("mid-packet commands, unused commands and a long packet.");
    if (fails == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
